// ----- sv/dtp_pkg.sv -----
// Package with the constants, types and codes shared by the digit trie files.
package dtp_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int RADIX      = 10;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = NODE_W + 1;
  localparam int IDX_DEPTH  = NODE_COUNT * RADIX;
  localparam int IDX_AW     = $clog2(IDX_DEPTH);
  localparam int NODE_DW    = RADIX + 1;
  localparam int DIGIT_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int USED_W     = 13;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_IDX_WAIT,
    S_NODE_WAIT,
    S_FRESH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_AW-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } idx_req_t;

  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  addr;
    logic [NODE_DW-1:0] wdata;
  } node_req_t;

endpackage

// ----- sv/dtp_if.sv -----
// Valid/ready channel interfaces for digit items and result items.
interface dtp_in_if import dtp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;
  logic               new_set;

  modport source (output valid, digit, last_digit, new_set, input ready);
  modport sink   (input valid, digit, last_digit, new_set, output ready);
  modport mon    (input valid, ready, digit, last_digit, new_set);
endinterface

interface dtp_out_if import dtp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                number_done;
  logic [USED_W-1:0]   nodes_used;

  modport source (output valid, status, number_done, nodes_used, input ready);
  modport sink   (input valid, status, number_done, nodes_used, output ready);
  modport mon    (input valid, ready, status, number_done, nodes_used);
endinterface

// ----- sv/dtp_ram.sv -----
// Generic single-port RAM with registered read data.
module dtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/dtp_ctrl.sv -----
// Sequencer that walks and grows the trie one digit at a time.
module dtp_ctrl import dtp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  dtp_in_if.sink             in_ch,
  dtp_out_if.source          out_ch,
  output idx_req_t           idx_req,
  input  logic [NODE_W-1:0]  idx_rdata,
  output node_req_t          node_req,
  input  logic [NODE_DW-1:0] node_rdata
);

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic [RADIX-1:0]    cur_present_r, cur_present_nxt;
  logic [RADIX-1:0]    root_present_r, root_present_nxt;
  logic [CNT_W-1:0]    alloc_r, alloc_nxt;
  status_t             status_r, status_nxt;
  logic [DIGIT_W-1:0]  digit_r, digit_nxt;
  logic                last_r, last_nxt;
  logic [NODE_W-1:0]   child_r, child_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_done_r, out_done_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  logic [RADIX-1:0]    eff_present;
  logic [RADIX-1:0]    digit_bit;
  logic [IDX_AW-1:0]   idx_addr;
  logic                slot_free;

  // The child slot of a node sits at node * 10 + digit.
  assign idx_addr = IDX_AW'({cur_r, 3'b000}) + IDX_AW'({cur_r, 1'b0}) + IDX_AW'(digit_r);
  assign eff_present = (cur_r == '0) ? root_present_r : cur_present_r;
  assign digit_bit = RADIX'(1) << digit_r;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.number_done = out_done_r;
  assign out_ch.nodes_used  = out_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cur_r          <= '0;
      cur_present_r  <= '0;
      root_present_r <= '0;
      alloc_r        <= CNT_W'(1);
      status_r       <= ST_OK;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cur_r          <= cur_nxt;
      cur_present_r  <= cur_present_nxt;
      root_present_r <= root_present_nxt;
      alloc_r        <= alloc_nxt;
      status_r       <= status_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r      <= digit_nxt;
    last_r       <= last_nxt;
    child_r      <= child_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
    out_used_r   <= out_used_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    cur_present_nxt  = cur_present_r;
    root_present_nxt = root_present_r;
    alloc_nxt        = alloc_r;
    status_nxt       = status_r;
    digit_nxt        = digit_r;
    last_nxt         = last_r;
    child_nxt        = child_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_done_nxt     = out_done_r;
    out_used_nxt     = out_used_r;
    idx_req.we       = 1'b0;
    idx_req.addr     = idx_addr;
    idx_req.wdata    = alloc_r[NODE_W-1:0];
    node_req.we      = 1'b0;
    node_req.addr    = cur_r;
    node_req.wdata   = {1'b0, eff_present | digit_bit};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          digit_nxt = in_ch.digit;
          last_nxt  = in_ch.last_digit;
          state_nxt = S_EMIT;
          if (in_ch.new_set) begin
            cur_nxt          = '0;
            alloc_nxt        = CNT_W'(1);
            status_nxt       = ST_OK;
            root_present_nxt = '0;
          end
          if (in_ch.new_set || status_r == ST_OK) begin
            if (in_ch.digit < DIGIT_W'(RADIX)) begin
              state_nxt = S_DECIDE;
            end else if (in_ch.last_digit) begin
              cur_nxt = '0;
            end
          end
        end
      end
      S_DECIDE: begin
        if ((eff_present & digit_bit) != '0) begin
          state_nxt = S_IDX_WAIT;
        end else if (alloc_r >= CNT_W'(NODE_COUNT)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_EMIT;
        end else begin
          idx_req.we = 1'b0 | 1'b1;
          if (cur_r == '0) begin
            root_present_nxt = eff_present | digit_bit;
          end else begin
            node_req.we = 1'b1;
          end
          state_nxt = S_FRESH;
        end
      end
      S_FRESH: begin
        node_req.we     = 1'b1;
        node_req.addr   = alloc_r[NODE_W-1:0];
        node_req.wdata  = {last_r, {RADIX{1'b0}}};
        alloc_nxt       = alloc_r + CNT_W'(1);
        cur_nxt         = last_r ? '0 : alloc_r[NODE_W-1:0];
        cur_present_nxt = '0;
        state_nxt       = S_EMIT;
      end
      S_IDX_WAIT: begin
        node_req.addr = idx_rdata;
        child_nxt     = idx_rdata;
        state_nxt     = S_NODE_WAIT;
      end
      S_NODE_WAIT: begin
        if (node_rdata[RADIX]) begin
          status_nxt = ST_CONFLICT;
        end else if (last_r) begin
          if (node_rdata[RADIX-1:0] != '0) begin
            status_nxt = ST_CONFLICT;
          end else begin
            node_req.we    = 1'b1;
            node_req.addr  = child_r;
            node_req.wdata = {1'b1, {RADIX{1'b0}}};
            cur_nxt        = '0;
          end
        end else begin
          cur_nxt         = child_r;
          cur_present_nxt = node_rdata[RADIX-1:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_done_nxt   = last_r;
          out_used_nxt   = USED_W'(alloc_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/digit_trie_prefix_conflict_check.sv -----
// Top level: digit trie prefix conflict checker with its two node stores.
// An ignored item (sticky status or a digit above nine) goes from idle straight to emit; an
// allocating digit passes decide and fresh, a digit that follows a child passes decide and
// the waits for the dependent child-slot read and node read. The input is ready again once the
// result is registered, so a new item waits for the last result, and longer while it is stalled.
// Synchronous active-low reset empties the set at once.
module digit_trie_prefix_conflict_check import dtp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dtp_in_if.sink    in_ch,
  dtp_out_if.source out_ch
);

  idx_req_t           idx_req;
  node_req_t          node_req;
  logic [NODE_W-1:0]  idx_rdata;
  logic [NODE_DW-1:0] node_rdata;

  dtp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .idx_req    (idx_req),
    .idx_rdata  (idx_rdata),
    .node_req   (node_req),
    .node_rdata (node_rdata)
  );

  dtp_ram #(
    .WIDTH (NODE_W),
    .DEPTH (IDX_DEPTH)
  ) u_idx_ram (
    .clk   (clk),
    .we    (idx_req.we),
    .addr  (idx_req.addr),
    .wdata (idx_req.wdata),
    .rdata (idx_rdata)
  );

  dtp_ram #(
    .WIDTH (NODE_DW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_req.we),
    .addr  (node_req.addr),
    .wdata (node_req.wdata),
    .rdata (node_rdata)
  );

endmodule

// ----- sv/dtp_checker.sv -----
// Port-level assertions for the digit trie checker and the bind that attaches them.
module dtp_checker import dtp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_number_done,
  input logic [USED_W-1:0]   out_nodes_used
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_nodes_used) && $stable(out_number_done))
    else $error("Stalled result item changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input ready right after an accepted item.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_CONFLICT
      || out_status == ST_FULL))
    else $error("Result item carries an unused status code.");

  a_root_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nodes_used != '0)
    else $error("Node count excludes the root.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result item valid after reset.");

endmodule

bind digit_trie_prefix_conflict_check dtp_checker u_dtp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_number_done (out_ch.number_done),
  .out_nodes_used  (out_ch.nodes_used)
);

// ----- dv/digit_trie_prefix_conflict_check_test.sv -----
// Self-checking testbench for the digit trie prefix conflict checker.
`timescale 1ns / 100ps

module digit_trie_prefix_conflict_check_test;
  import dtp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                number_done;
    logic [USED_W-1:0]   nodes_used;
  } result_t;

  logic clk;
  logic rst_n;

  dtp_in_if  in_ch ();
  dtp_out_if out_ch ();

  digit_trie_prefix_conflict_check dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  result_t pending_results[$];
  int      errors;
  int      items_sent;
  int      cycle_cnt;
  bit      calm;

  logic [NODE_W-1:0] trie_child [IDX_DEPTH];
  logic [RADIX-1:0]  trie_present [NODE_COUNT];
  bit                trie_ends [NODE_COUNT];
  int unsigned       trie_cur;
  int unsigned       trie_used;
  status_t           trie_status;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  task automatic clear_trie();
    for (int i = 0; i < NODE_COUNT; i++) begin
      trie_present[i] = '0;
      trie_ends[i]    = 1'b0;
    end
    trie_cur    = 0;
    trie_used   = 1;
    trie_status = ST_OK;
  endtask

  task automatic walk_digit(input logic [DIGIT_W-1:0] d, input logic last);
    int unsigned node;
    node = trie_cur;
    if (d >= RADIX) begin
      if (last) trie_cur = 0;
      return;
    end
    if (trie_present[node][d]) begin
      node = trie_child[node * RADIX + d];
      if (trie_ends[node]) begin
        trie_status = ST_CONFLICT;
        return;
      end
    end else begin
      if (trie_used >= NODE_COUNT) begin
        trie_status = ST_FULL;
        return;
      end
      trie_child[node * RADIX + d] = NODE_W'(trie_used);
      trie_present[node][d]        = 1'b1;
      trie_present[trie_used]      = '0;
      trie_ends[trie_used]         = 1'b0;
      node = trie_used;
      trie_used++;
    end
    if (last) begin
      if (trie_present[node] != '0) begin
        trie_status = ST_CONFLICT;
        return;
      end
      trie_ends[node] = 1'b1;
      trie_cur = 0;
    end else begin
      trie_cur = node;
    end
  endtask

  task automatic predict_result(input logic [DIGIT_W-1:0] d, input logic last,
                                input logic ns, output result_t r);
    if (ns) clear_trie();
    if (trie_status == ST_OK) walk_digit(d, last);
    r.status      = trie_status;
    r.number_done = last;
    r.nodes_used  = USED_W'(trie_used);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic [DIGIT_W-1:0] d, input logic last, input logic ns);
    result_t r;
    while (take_gap()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.digit      = d;
    in_ch.last_digit = last;
    in_ch.new_set    = ns;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_result(d, last, ns, r);
    pending_results.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  // The number reads as hex: the most significant used nibble is the first digit.
  task automatic send_number(input logic [31:0] digs, input int len, input bit ns);
    for (int i = 0; i < len; i++) begin
      send_item(digs[4 * (len - 1 - i) +: 4], i == len - 1, ns && i == 0);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !take_gap();
    end
  end

  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result item with nothing pending, status %0d",
                                    out_ch.status));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.number_done !== want.number_done)
            report_mismatch($sformatf("number_done %0d, expected %0d",
                                      out_ch.number_done, want.number_done));
          if (out_ch.nodes_used !== want.nodes_used)
            report_mismatch($sformatf("nodes_used %0d, expected %0d",
                                      out_ch.nodes_used, want.nodes_used));
        end
      end
    end
  end

  task automatic test_consistent_set();
    send_number(32'h0, 1, 1'b1);
    send_number(32'h19, 2, 1'b0);
    send_number(32'h98, 2, 1'b0);
  endtask

  task automatic test_duplicate();
    send_number(32'h45, 2, 1'b1);
    send_number(32'h45, 2, 1'b0);
    send_item(4'd3, 1'b1, 1'b0);
  endtask

  task automatic test_prefix_conflicts();
    send_number(32'h123, 3, 1'b1);
    send_number(32'h12, 2, 1'b0);
    send_number(32'h12, 2, 1'b1);
    send_number(32'h123, 3, 1'b0);
  endtask

  task automatic test_bad_digits();
    send_item(4'd1, 1'b0, 1'b1);
    send_item(4'd15, 1'b0, 1'b0);
    send_item(4'd10, 1'b1, 1'b0);
    send_number(32'h1, 1, 1'b0);
    send_item(4'd12, 1'b1, 1'b0);
    send_item(4'd9, 1'b0, 1'b1);
  endtask

  // A single unterminated chain allocates one node per digit until the store is full.
  task automatic test_store_full();
    send_item(4'($urandom_range(0, 9)), 1'b0, 1'b1);
    repeat (NODE_COUNT - 2) send_item(4'($urandom_range(0, 9)), 1'b0, 1'b0);
    send_item(4'($urandom_range(0, 9)), 1'b1, 1'b0);
    send_item(4'($urandom_range(0, 9)), 1'b1, 1'b0);
    send_item(4'($urandom_range(0, 9)), 1'b0, 1'b0);
    send_number(32'h7, 1, 1'b1);
  endtask

  task automatic test_random_sets();
    logic [31:0] nums [8];
    int          lens [8];
    logic [31:0] digs;
    int          len;
    int          count;
    int          pick;
    int          start;
    bit          tight;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      calm = (items_sent - start >= 350) && (items_sent - start < 500);
      if ($urandom_range(0, 99) < 80) begin
        count = 0;
        tight = 1'($urandom_range(0, 1));
        for (int j = 0, k = $urandom_range(1, 6); j < k; j++) begin
          if (count > 0 && $urandom_range(0, 99) < 20) begin
            pick = $urandom_range(0, count - 1);
            digs = nums[pick];
            len  = lens[pick];
            case ($urandom_range(0, 2))
              1: begin
                if (len > 1) begin
                  digs = digs >> 4;
                  len--;
                end
              end
              2: begin
                if (len < 8) begin
                  digs = {digs[27:0], 4'($urandom_range(0, 9))};
                  len++;
                end
              end
              default: ;
            endcase
          end else begin
            len  = $urandom_range(1, 5);
            digs = '0;
            for (int i = 0; i < len; i++) begin
              digs = {digs[27:0], tight ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 9))};
            end
          end
          if (count < 8) begin
            nums[count] = digs;
            lens[count] = len;
            count++;
          end
          send_number(digs, len, j == 0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 7) == 0);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.digit      = '0;
    in_ch.last_digit = 1'b0;
    in_ch.new_set    = 1'b0;
    rst_n            = 1'b0;
    calm             = 1'b0;
    errors           = 0;
    items_sent       = 0;
    clear_trie();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_consistent_set();
    test_duplicate();
    test_prefix_conflicts();
    test_bad_digits();
    test_store_full();
    test_random_sets();

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
